// ===== sv/hslg_pkg.sv =====
// ----------------------------------------------------------------------------
// hslg_pkg
// Shared types, constants and saturation helper for the Huber SVM
// loss/gradient block.
// ----------------------------------------------------------------------------
package hslg_pkg;

   localparam int VECTOR_LENGTH_DEF = 32;
   localparam int VALUE_WIDTH_DEF   = 32;

   localparam int ACC_W  = 48;
   localparam int OPB_W  = 33;
   localparam int WIDE_W = 60;
   localparam int ELEM_W = 32;
   localparam int IDX_W  = 5;
   localparam int FRAC_W = 24;

   localparam logic signed [WIDE_W-1:0] Q_ONE = WIDE_W'(64'sd16777216);
   localparam logic signed [WIDE_W-1:0] ACC_MAX_W = WIDE_W'(64'sd140737488355327);
   localparam logic signed [WIDE_W-1:0] ACC_MIN_W = WIDE_W'(-64'sd140737488355328);

   localparam logic [30:0] HUBER_RST = 31'd8388608;
   localparam logic [30:0] INV2H_RST = 31'd16777216;
   localparam logic [30:0] LAMBDA_RST = 31'd0;
   localparam logic [24:0] INVN_RST  = 25'd16777216;
   localparam logic [5:0]  ALEN_RST  = 6'd32;

   typedef enum logic [1:0] {
      RK_WEIGHT = 2'd0,
      RK_BIAS   = 2'd1,
      RK_SAMPLE = 2'd2,
      RK_FINISH = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_HUBER  = 3'd0,
      CSR_INV2H  = 3'd1,
      CSR_LAMBDA = 3'd2,
      CSR_INVN   = 3'd3,
      CSR_ALEN   = 3'd4
   } csr_addr_type;

   typedef enum logic [1:0] {
      RG_FLAT   = 2'd0,
      RG_LINEAR = 2'd1,
      RG_QUAD   = 2'd2
   } region_type;

   typedef enum logic [1:0] {
      MU_IDLE,
      MU_LO,
      MU_HI,
      MU_SUM
   } mul_state_type;

   typedef enum logic [4:0] {
      SQ_IDLE,
      SQ_DOT_GO,
      SQ_DOT_WAIT,
      SQ_REGION,
      SQ_T_GO,
      SQ_T_WAIT,
      SQ_TM_GO,
      SQ_TM_WAIT,
      SQ_LQ_GO,
      SQ_LQ_WAIT,
      SQ_GU_RD,
      SQ_GU_GO,
      SQ_GT_WAIT,
      SQ_GS_GO,
      SQ_GS_WAIT,
      SQ_FN_RD,
      SQ_RW_GO,
      SQ_RW_WAIT,
      SQ_BI_GO,
      SQ_BI_WAIT,
      SQ_WW_GO,
      SQ_WW_WAIT,
      SQ_BW_GO,
      SQ_BW_WAIT,
      SQ_F1_GO,
      SQ_F1_WAIT,
      SQ_F2_GO,
      SQ_F2_WAIT
   } seq_state_type;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      if (v > ACC_MAX_W) begin
         r = ACC_MAX_W[ACC_W-1:0];
      end else if (v < ACC_MIN_W) begin
         r = ACC_MIN_W[ACC_W-1:0];
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/hslg_ram.sv =====
// ----------------------------------------------------------------------------
// hslg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hslg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/hslg_mul.sv =====
// ----------------------------------------------------------------------------
// hslg_mul
// Shared Q24.24 x Q9.24 multiplier: floor(a*b / 2^24), optionally negated,
// saturated to 48 bits, from two 25x33 partial products on one multiplier.
// ----------------------------------------------------------------------------
module hslg_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 neg,
   input  logic signed [hslg_pkg::ACC_W-1:0]    op_a,
   input  logic signed [hslg_pkg::OPB_W-1:0]    op_b,
   output logic                                 done,
   output logic signed [hslg_pkg::ACC_W-1:0]    result
);
   import hslg_pkg::*;

   localparam int PROD_W = 25 + OPB_W;

   mul_state_type state_ff, state_in;
   logic signed [ACC_W-1:0]  a_ff;
   logic signed [OPB_W-1:0]  b_ff;
   logic                     neg_ff;
   logic signed [PROD_W-1:0] plo_ff, phi_ff, prod;
   logic signed [24:0]       x_sel;
   logic signed [WIDE_W-1:0] sum;
   logic signed [ACC_W-1:0]  res_ff;
   logic                     done_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MU_IDLE: if (start) state_in = MU_LO;
         MU_LO:   state_in = MU_HI;
         MU_HI:   state_in = MU_SUM;
         MU_SUM:  state_in = MU_IDLE;
         default: state_in = MU_IDLE;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         MU_HI:   x_sel = {a_ff[ACC_W-1], a_ff[ACC_W-1:FRAC_W]};
         default: x_sel = {1'b0, a_ff[FRAC_W-1:0]};
      endcase
   end

   assign prod = x_sel * b_ff;
   assign sum  = WIDE_W'(phi_ff) + WIDE_W'(plo_ff >>> FRAC_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == MU_SUM);
      end
      if (state_ff == MU_IDLE && start) begin
         a_ff   <= op_a;
         b_ff   <= op_b;
         neg_ff <= neg;
      end
      if (state_ff == MU_LO) plo_ff <= prod;
      if (state_ff == MU_HI) phi_ff <= prod;
      if (state_ff == MU_SUM) res_ff <= sat_acc(neg_ff ? -sum : sum);
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== sv/huber_svm_loss_gradient.sv =====
// ----------------------------------------------------------------------------
// huber_svm_loss_gradient
// Huber-smoothed hinge SVM objective and gradient, signed Q8.24, one shared
// multiplier under a sequencer.
// ----------------------------------------------------------------------------
// channel  handshake            payload
// req      start / busy         req_type, req_elem_index, req_element_value,
//                               req_last_of_sample
// rsp      rsp_strobe (1 cycle) rsp_out_index, rsp_out_value, rsp_is_loss,
//                               rsp_last_result
// csr      APB psel/penable     paddr, pwdata, prdata, pready
//
// Each multiply is issued from a GO state and waits on the shared multiplier.
// Load: one RAM write on accept. Sample element: one multiply; a last element
// adds the loss multiply (after two more in the quadratic region) plus one
// (linear) or two (quadratic) gradient multiplies per active element, none in
// the flat region. Finish: four multiplies per element plus two for the loss.
// Synchronous active-high reset clears the sequencer, dot and loss accumulators.
// Results cannot be stalled; busy holds off new transactions.
// ----------------------------------------------------------------------------
module huber_svm_loss_gradient #(
   parameter int VECTOR_LENGTH = hslg_pkg::VECTOR_LENGTH_DEF,
   parameter int VALUE_WIDTH   = hslg_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_type,
   input  logic [hslg_pkg::IDX_W-1:0]             req_elem_index,
   input  logic signed [hslg_pkg::ELEM_W-1:0]     req_element_value,
   input  logic                                   req_last_of_sample,
   output logic                                   rsp_strobe,
   output logic [hslg_pkg::IDX_W-1:0]             rsp_out_index,
   output logic signed [VALUE_WIDTH-1:0]          rsp_out_value,
   output logic                                   rsp_is_loss,
   output logic                                   rsp_last_result,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [4:0]                             paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);
   import hslg_pkg::*;

   localparam int AW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
   localparam int CW = $clog2(VECTOR_LENGTH + 1);
   localparam logic signed [ACC_W-1:0] OUT_MAX =
      ACC_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

   // configuration
   logic [30:0] huber_ff, inv2h_ff, lambda_ff;
   logic [24:0] invn_ff;
   logic [5:0]  alen_ff;
   logic        csr_wr;
   csr_addr_type csr_sel;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_sel = csr_addr_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         huber_ff  <= HUBER_RST;
         inv2h_ff  <= INV2H_RST;
         lambda_ff <= LAMBDA_RST;
         invn_ff   <= INVN_RST;
         alen_ff   <= ALEN_RST;
      end else if (csr_wr) begin
         unique case (csr_sel)
            CSR_HUBER:  huber_ff  <= pwdata[30:0];
            CSR_INV2H:  inv2h_ff  <= pwdata[30:0];
            CSR_LAMBDA: lambda_ff <= pwdata[30:0];
            CSR_INVN:   invn_ff   <= pwdata[24:0];
            CSR_ALEN:   alen_ff   <= pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_HUBER:  prdata = {1'b0, huber_ff};
         CSR_INV2H:  prdata = {1'b0, inv2h_ff};
         CSR_LAMBDA: prdata = {1'b0, lambda_ff};
         CSR_INVN:   prdata = {7'd0, invn_ff};
         CSR_ALEN:   prdata = {26'd0, alen_ff};
         default:    prdata = 32'd0;
      endcase
   end

   // effective length
   logic [CW-1:0] eff_len;
   assign eff_len = (int'(alen_ff) < VECTOR_LENGTH) ? CW'(alen_ff) : CW'(VECTOR_LENGTH);

   // sequencer state and datapath registers
   seq_state_type state_ff, state_in;
   region_type    region_ff, region_now;
   logic [CW-1:0] i_ff;
   logic          last_ff;
   logic signed [ELEM_W-1:0] val_ff;
   logic signed [ACC_W-1:0]  dot_ff, loss_ff, m_ff, t_ff, lossv_ff, g_ff;
   logic signed [ACC_W-1:0]  sumsq_ff, bdot_ff, fx_ff;
   logic [VECTOR_LENGTH-1:0] gvld_ff;
   logic                     out_stb_ff, out_loss_ff;
   logic [IDX_W-1:0]         out_idx_ff;
   logic signed [VALUE_WIDTH-1:0] out_val_ff;

   logic accept, in_range, in_len, idx_last;
   req_kind_type kind;

   assign busy     = (state_ff != SQ_IDLE);
   assign accept   = start & ~busy;
   assign kind     = req_kind_type'(req_type);
   assign in_range = (int'(req_elem_index) < VECTOR_LENGTH);
   assign in_len   = ({1'b0, req_elem_index} < 6'(eff_len));
   assign idx_last = ((i_ff + CW'(1)) == eff_len);

   // memories
   logic [AW-1:0] raddr, waddr_req;
   logic [ELEM_W-1:0] w_rd, b_rd, s_rd;
   logic [ACC_W-1:0]  gr_rd;
   logic w_we, b_we, s_we, g_we;
   logic signed [ACC_W-1:0] g_old, g_wdata;

   assign waddr_req = AW'(req_elem_index);
   assign raddr     = busy ? i_ff[AW-1:0] : waddr_req;
   assign w_we      = accept & (kind == RK_WEIGHT) & in_range;
   assign b_we      = accept & (kind == RK_BIAS) & in_range;
   assign s_we      = accept & (kind == RK_SAMPLE) & in_range;

   hslg_ram #(.WIDTH(ELEM_W), .DEPTH(VECTOR_LENGTH)) u_wram (
      .clock(clock), .we(w_we), .waddr(waddr_req), .wdata(req_element_value),
      .raddr(raddr), .rdata(w_rd)
   );
   hslg_ram #(.WIDTH(ELEM_W), .DEPTH(VECTOR_LENGTH)) u_bram (
      .clock(clock), .we(b_we), .waddr(waddr_req), .wdata(req_element_value),
      .raddr(raddr), .rdata(b_rd)
   );
   hslg_ram #(.WIDTH(ELEM_W), .DEPTH(VECTOR_LENGTH)) u_sram (
      .clock(clock), .we(s_we), .waddr(waddr_req), .wdata(req_element_value),
      .raddr(raddr), .rdata(s_rd)
   );
   hslg_ram #(.WIDTH(ACC_W), .DEPTH(VECTOR_LENGTH)) u_gram (
      .clock(clock), .we(g_we), .waddr(i_ff[AW-1:0]), .wdata(g_wdata),
      .raddr(raddr), .rdata(gr_rd)
   );

   // shared multiplier
   logic mul_start, mul_done, mul_neg;
   logic signed [ACC_W-1:0] mul_a, mul_res;
   logic signed [OPB_W-1:0] mul_b;

   hslg_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .neg(mul_neg), .op_a(mul_a),
      .op_b(mul_b), .done(mul_done), .result(mul_res)
   );

   logic signed [ACC_W-1:0] w_s, b_s, s_s;
   logic signed [OPB_W-1:0] w_b, s_b, b_bb, inv2h_b, lambda_b, invn_b, val_b;
   assign w_s      = ACC_W'(signed'(w_rd));
   assign b_s      = ACC_W'(signed'(b_rd));
   assign s_s      = ACC_W'(signed'(s_rd));
   assign w_b      = OPB_W'(signed'(w_rd));
   assign b_bb     = OPB_W'(signed'(b_rd));
   assign s_b      = OPB_W'(signed'(s_rd));
   assign val_b    = OPB_W'(val_ff);
   assign inv2h_b  = signed'(OPB_W'(inv2h_ff));
   assign lambda_b = signed'(OPB_W'(lambda_ff));
   assign invn_b   = signed'(OPB_W'(invn_ff));

   // region and loss terms
   logic signed [WIDE_W-1:0] dot_w, one_ph, one_mh, m_w, lin_w;
   assign dot_w  = WIDE_W'(dot_ff);
   assign one_ph = Q_ONE + signed'(WIDE_W'(huber_ff));
   assign one_mh = Q_ONE - signed'(WIDE_W'(huber_ff));
   assign m_w    = one_ph - dot_w;
   assign lin_w  = Q_ONE - dot_w;

   always_comb begin
      if (dot_w > one_ph) begin
         region_now = RG_FLAT;
      end else if (dot_w < one_mh) begin
         region_now = RG_LINEAR;
      end else begin
         region_now = RG_QUAD;
      end
   end

   assign g_old   = gvld_ff[i_ff[AW-1:0]] ? signed'(gr_rd) : '0;
   assign g_wdata = sat_acc(WIDE_W'(g_old) + WIDE_W'(mul_res));
   assign g_we    = (state_ff == SQ_GS_WAIT) & mul_done;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               case (kind)
                  RK_SAMPLE: begin
                     if (in_range && in_len) state_in = SQ_DOT_GO;
                     else if (req_last_of_sample) state_in = SQ_REGION;
                  end
                  RK_FINISH: state_in = (eff_len == '0) ? SQ_F1_GO : SQ_FN_RD;
                  default: ;
               endcase
            end
         end
         SQ_DOT_GO:   state_in = SQ_DOT_WAIT;
         SQ_DOT_WAIT: if (mul_done) state_in = last_ff ? SQ_REGION : SQ_IDLE;
         SQ_REGION:   state_in = (region_now == RG_QUAD) ? SQ_T_GO : SQ_LQ_GO;
         SQ_T_GO:     state_in = SQ_T_WAIT;
         SQ_T_WAIT:   if (mul_done) state_in = SQ_TM_GO;
         SQ_TM_GO:    state_in = SQ_TM_WAIT;
         SQ_TM_WAIT:  if (mul_done) state_in = SQ_LQ_GO;
         SQ_LQ_GO:    state_in = SQ_LQ_WAIT;
         SQ_LQ_WAIT: begin
            if (mul_done) begin
               state_in = (region_ff == RG_FLAT || eff_len == '0) ? SQ_IDLE : SQ_GU_RD;
            end
         end
         SQ_GU_RD:    state_in = SQ_GU_GO;
         SQ_GU_GO:    state_in = (region_ff == RG_QUAD) ? SQ_GT_WAIT : SQ_GS_GO;
         SQ_GT_WAIT:  if (mul_done) state_in = SQ_GS_GO;
         SQ_GS_GO:    state_in = SQ_GS_WAIT;
         SQ_GS_WAIT:  if (mul_done) state_in = idx_last ? SQ_IDLE : SQ_GU_RD;
         SQ_FN_RD:    state_in = SQ_RW_GO;
         SQ_RW_GO:    state_in = SQ_RW_WAIT;
         SQ_RW_WAIT:  if (mul_done) state_in = SQ_BI_GO;
         SQ_BI_GO:    state_in = SQ_BI_WAIT;
         SQ_BI_WAIT:  if (mul_done) state_in = SQ_WW_GO;
         SQ_WW_GO:    state_in = SQ_WW_WAIT;
         SQ_WW_WAIT:  if (mul_done) state_in = SQ_BW_GO;
         SQ_BW_GO:    state_in = SQ_BW_WAIT;
         SQ_BW_WAIT:  if (mul_done) state_in = idx_last ? SQ_F1_GO : SQ_FN_RD;
         SQ_F1_GO:    state_in = SQ_F1_WAIT;
         SQ_F1_WAIT:  if (mul_done) state_in = SQ_F2_GO;
         SQ_F2_GO:    state_in = SQ_F2_WAIT;
         SQ_F2_WAIT:  if (mul_done) state_in = SQ_IDLE;
         default:     state_in = SQ_IDLE;
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_start = 1'b0;
      mul_neg   = 1'b0;
      mul_a     = w_s;
      mul_b     = val_b;
      unique case (state_ff)
         SQ_DOT_GO: begin
            mul_start = 1'b1; mul_a = w_s; mul_b = val_b;
         end
         SQ_T_GO: begin
            mul_start = 1'b1; mul_a = m_ff; mul_b = inv2h_b;
         end
         SQ_TM_GO: begin
            mul_start = 1'b1; mul_a = t_ff; mul_b = m_ff[OPB_W-1:0];
         end
         SQ_LQ_GO: begin
            mul_start = 1'b1; mul_a = lossv_ff; mul_b = invn_b;
         end
         SQ_GU_GO: begin
            mul_start = (region_ff == RG_QUAD); mul_neg = 1'b1;
            mul_a = t_ff; mul_b = s_b;
         end
         SQ_GS_GO: begin
            mul_start = 1'b1; mul_a = g_ff; mul_b = invn_b;
         end
         SQ_RW_GO: begin
            mul_start = 1'b1; mul_a = w_s; mul_b = lambda_b;
         end
         SQ_BI_GO: begin
            mul_start = 1'b1; mul_a = b_s; mul_b = invn_b;
         end
         SQ_WW_GO: begin
            mul_start = 1'b1; mul_a = w_s; mul_b = w_b;
         end
         SQ_BW_GO: begin
            mul_start = 1'b1; mul_a = b_s; mul_b = w_b;
         end
         SQ_F1_GO: begin
            mul_start = 1'b1; mul_a = sumsq_ff; mul_b = lambda_b;
         end
         SQ_F2_GO: begin
            mul_start = 1'b1; mul_a = bdot_ff; mul_b = invn_b;
         end
         default: ;
      endcase
   end

   // output clamp
   logic signed [ACC_W-1:0] clamp_src, clamp_val;
   logic signed [WIDE_W-1:0] fx_sum;
   assign fx_sum    = WIDE_W'(fx_ff) + WIDE_W'(mul_res);
   assign clamp_src = (state_ff == SQ_F2_WAIT) ? sat_acc(fx_sum) : g_ff;
   assign clamp_val = (clamp_src > OUT_MAX) ? OUT_MAX :
                      (clamp_src < OUT_MIN) ? OUT_MIN : clamp_src;

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SQ_IDLE;
         dot_ff     <= '0;
         loss_ff    <= '0;
         gvld_ff    <= '0;
         out_stb_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_stb_ff <= 1'b0;
         unique case (state_ff)
            SQ_IDLE: begin
               if (accept) begin
                  val_ff  <= req_element_value;
                  last_ff <= req_last_of_sample;
                  i_ff    <= '0;
                  sumsq_ff <= '0;
                  bdot_ff  <= '0;
               end
            end
            SQ_DOT_WAIT: begin
               if (mul_done) dot_ff <= sat_acc(dot_w + WIDE_W'(mul_res));
            end
            SQ_REGION: begin
               region_ff <= region_now;
               m_ff      <= m_w[ACC_W-1:0];
               lossv_ff  <= (region_now == RG_LINEAR) ? sat_acc(lin_w) : '0;
               dot_ff    <= '0;
               i_ff      <= '0;
            end
            SQ_T_WAIT: if (mul_done) t_ff <= mul_res;
            SQ_TM_WAIT: if (mul_done) lossv_ff <= mul_res >>> 1;
            SQ_LQ_WAIT: begin
               if (mul_done) loss_ff <= sat_acc(WIDE_W'(loss_ff) + WIDE_W'(mul_res));
            end
            SQ_GU_GO: if (region_ff == RG_LINEAR) g_ff <= -s_s;
            SQ_GT_WAIT: if (mul_done) g_ff <= mul_res;
            SQ_GS_WAIT: begin
               if (mul_done) begin
                  gvld_ff[i_ff[AW-1:0]] <= 1'b1;
                  i_ff <= i_ff + CW'(1);
               end
            end
            SQ_RW_WAIT: if (mul_done) g_ff <= g_wdata;
            SQ_BI_WAIT: begin
               if (mul_done) g_ff <= sat_acc(WIDE_W'(g_ff) + WIDE_W'(mul_res));
            end
            SQ_WW_WAIT: begin
               if (mul_done) sumsq_ff <= sat_acc(WIDE_W'(sumsq_ff) + WIDE_W'(mul_res));
            end
            SQ_BW_WAIT: begin
               if (mul_done) begin
                  bdot_ff     <= sat_acc(WIDE_W'(bdot_ff) + WIDE_W'(mul_res));
                  out_stb_ff  <= 1'b1;
                  out_loss_ff <= 1'b0;
                  out_idx_ff  <= IDX_W'(i_ff);
                  out_val_ff  <= clamp_val[VALUE_WIDTH-1:0];
                  i_ff        <= i_ff + CW'(1);
               end
            end
            SQ_F1_WAIT: begin
               if (mul_done) fx_ff <= sat_acc(WIDE_W'(loss_ff) + WIDE_W'(mul_res >>> 1));
            end
            SQ_F2_WAIT: begin
               if (mul_done) begin
                  out_stb_ff  <= 1'b1;
                  out_loss_ff <= 1'b1;
                  out_idx_ff  <= '0;
                  out_val_ff  <= clamp_val[VALUE_WIDTH-1:0];
                  gvld_ff     <= '0;
                  loss_ff     <= '0;
                  dot_ff      <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_strobe      = out_stb_ff;
   assign rsp_out_index   = out_idx_ff;
   assign rsp_out_value   = out_val_ff;
   assign rsp_is_loss     = out_loss_ff;
   assign rsp_last_result = out_loss_ff;

endmodule
